### rtl/assert_macros.svh
// Assertion macros used by the framer core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Checks prop at every rising edge of clk while rst is low.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Checks that cond never holds at a rising edge of clk while rst is low.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_NEVER(label, cond, msg)
`endif

`endif

### rtl/nlfc_pkg.sv
// Package with constants, types and helpers for the NMEA line framer.
`default_nettype none
package nlfc_pkg;

  localparam int LINE_MAX = 82;
  localparam int FILL_W = 7;
  localparam int CNT_W = 32;
  localparam int MIN_LEN = 4;
  localparam int STAR_TAIL = 6;
  localparam int HEX_DIGITS = 2;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  typedef struct packed {
    logic              ok;
    logic [FILL_W-1:0] len;
    logic [7:0]        sum;
    logic [CNT_W-1:0]  sent;
    logic [CNT_W-1:0]  err;
    logic [CNT_W-1:0]  bytes;
    logic              alive;
  } result_t;

  // Returns the digit value in the low four bits; bit 4 set means not a hex digit.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = {1'b0, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      v = {1'b0, c[3:0] + 4'd9};
    end else begin
      v = 5'h10;
    end
    return v;
  endfunction

endpackage
`default_nettype wire

### rtl/nmea_line_framer_checksum_core.sv
// NMEA 0183 sentence framer, checksum checker and link statistics.
//
// Serial bytes come in on the s_ group, one word per byte. A '$' restarts the
// line, CR or LF closes it. A closed line that is non-empty and not overrun
// yields one result word on the m_ group: the verdict in m_tuser, and the line
// length, the computed XOR, the sentence, error and byte totals and the alive
// flag in m_tdata.
// Every byte is handled in the cycle it is accepted, so a byte can be taken in
// every clock cycle while s_tready is high. A result word is written into the
// output buffer when its terminator byte is accepted.
// Results go through a two-entry output buffer. When the receiver stalls, one
// more result can be held, and s_tready drops only when both entries are full.
// Lines longer than LINE_MAX bytes are dropped without a result.
// A synchronous reset clears the line state, the counters, the alive flag and
// the output buffer.
`default_nettype none
`include "assert_macros.svh"

module nmea_line_framer_checksum_core
  import nlfc_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [7:0]   s_tdata,   // rx_byte
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [111:0]      m_tdata,   // line_length, computed_sum, sentence_total,
                                       // error_total, byte_total, link_alive
  output logic              m_tuser    // sentence_ok
);

  // Line and statistics state.
  logic [FILL_W-1:0] line_fill, line_fill_next;
  logic              overrun, overrun_next;
  logic              sdollar, sdollar_next;
  logic [7:0]        run_xor, run_xor_next;
  logic [FILL_W-1:0] star_pos, star_pos_next;
  logic              star_seen, star_seen_next;
  logic [7:0]        xor_star, xor_star_next;
  logic [7:0]        hex_hi, hex_hi_next;
  logic [7:0]        hex_lo, hex_lo_next;
  logic [CNT_W-1:0]  sent_cnt, sent_cnt_next;
  logic [CNT_W-1:0]  err_cnt, err_cnt_next;
  logic [CNT_W-1:0]  byte_cnt, byte_cnt_next;
  logic              alive, alive_next;

  // Output buffer.
  result_t out_res, skid_res, new_res;
  logic    out_valid, skid_valid;

  logic accept, pop, push;
  logic is_dollar, is_term;
  logic [FILL_W-1:0] fill_eff;
  logic              ovr_eff;
  logic [4:0]        hv, lv;
  logic              ok;
  logic [FILL_W:0]   len_w, star_w;

  assign s_tready = !skid_valid;
  assign accept = s_tvalid && s_tready;
  assign pop = out_valid && m_tready;

  assign is_dollar = (s_tdata == CH_DOLLAR);
  assign is_term = (s_tdata == CH_CR) || (s_tdata == CH_LF);
  assign fill_eff = is_dollar ? '0 : line_fill;
  assign ovr_eff = is_dollar ? 1'b0 : overrun;

  assign hv = hex_value(hex_hi);
  assign lv = hex_value(hex_lo);
  assign len_w = {1'b0, line_fill};
  assign star_w = {1'b0, star_pos};

  // The last star must sit in the final five bytes with two digits after it.
  assign ok = (len_w >= (FILL_W+1)'(MIN_LEN)) && sdollar && star_seen &&
              (star_w + (FILL_W+1)'(STAR_TAIL) > len_w) &&
              (star_w + (FILL_W+1)'(HEX_DIGITS) < len_w) &&
              !hv[4] && !lv[4] && ({hv[3:0], lv[3:0]} == xor_star);

  assign push = accept && is_term && (fill_eff != '0) && !ovr_eff;

  always_comb begin
    line_fill_next = line_fill;
    overrun_next = overrun;
    sdollar_next = sdollar;
    run_xor_next = run_xor;
    star_pos_next = star_pos;
    star_seen_next = star_seen;
    xor_star_next = xor_star;
    hex_hi_next = hex_hi;
    hex_lo_next = hex_lo;
    sent_cnt_next = sent_cnt;
    err_cnt_next = err_cnt;
    byte_cnt_next = byte_cnt + 1'b1;
    alive_next = alive;

    if (is_term) begin
      if (fill_eff != '0 && !ovr_eff) begin
        if (ok) begin
          sent_cnt_next = sent_cnt + 1'b1;
          alive_next = 1'b1;
        end else begin
          err_cnt_next = err_cnt + 1'b1;
        end
      end
      line_fill_next = '0;
      overrun_next = 1'b0;
    end else if (fill_eff >= FILL_W'(LINE_MAX)) begin
      line_fill_next = fill_eff;
      overrun_next = 1'b1;
    end else begin
      overrun_next = ovr_eff;
      if (fill_eff == '0) begin
        sdollar_next = is_dollar;
        run_xor_next = '0;
        star_pos_next = '0;
        star_seen_next = 1'b0;
        xor_star_next = '0;
        hex_hi_next = '0;
        hex_lo_next = '0;
      end else begin
        if (star_seen && fill_eff == star_pos + 1'b1) begin
          hex_hi_next = s_tdata;
        end
        if (star_seen && fill_eff == star_pos + FILL_W'(HEX_DIGITS)) begin
          hex_lo_next = s_tdata;
        end
        if (s_tdata == CH_STAR) begin
          star_pos_next = fill_eff;
          star_seen_next = 1'b1;
          xor_star_next = run_xor;
        end
        run_xor_next = run_xor ^ s_tdata;
      end
      line_fill_next = fill_eff + 1'b1;
    end
  end

  always_comb begin
    new_res.ok = ok;
    new_res.len = line_fill;
    new_res.sum = star_seen ? xor_star : 8'h00;
    new_res.sent = sent_cnt_next;
    new_res.err = err_cnt_next;
    new_res.bytes = byte_cnt_next;
    new_res.alive = alive_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_fill <= '0;
      overrun <= 1'b0;
      sdollar <= 1'b0;
      run_xor <= '0;
      star_pos <= '0;
      star_seen <= 1'b0;
      xor_star <= '0;
      hex_hi <= '0;
      hex_lo <= '0;
      sent_cnt <= '0;
      err_cnt <= '0;
      byte_cnt <= '0;
      alive <= 1'b0;
    end else if (accept) begin
      line_fill <= line_fill_next;
      overrun <= overrun_next;
      sdollar <= sdollar_next;
      run_xor <= run_xor_next;
      star_pos <= star_pos_next;
      star_seen <= star_seen_next;
      xor_star <= xor_star_next;
      hex_hi <= hex_hi_next;
      hex_lo <= hex_lo_next;
      sent_cnt <= sent_cnt_next;
      err_cnt <= err_cnt_next;
      byte_cnt <= byte_cnt_next;
      alive <= alive_next;
    end
  end

  // Input is blocked while the second entry is full, so a push then cannot occur.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      if (skid_valid) begin
        out_valid <= 1'b1;
        skid_valid <= push;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      if (skid_valid) begin
        out_res <= skid_res;
        if (push) begin
          skid_res <= new_res;
        end
      end else if (push) begin
        out_res <= new_res;
      end
    end else if (push) begin
      skid_res <= new_res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser = out_res.ok;
  assign m_tdata = {out_res.alive, out_res.bytes, out_res.err, out_res.sent,
                    out_res.sum, out_res.len};

  `ASSERT_CLK(a_skid_behind_head, skid_valid |-> out_valid, "second entry full while head empty")
  `ASSERT_NEVER(a_fill_bound, line_fill > FILL_W'(LINE_MAX), "line fill beyond limit")
  `ASSERT_CLK(a_overrun_full, overrun |-> (line_fill == FILL_W'(LINE_MAX)), "overrun on short line")
  `ASSERT_CLK(a_byte_count, accept |=> (byte_cnt == $past(byte_cnt) + 1'b1), "byte count slip")

endmodule
`default_nettype wire

### tb/nmea_verdict_checker.sv
// Line verdict predictor and result word checker for the NMEA line framer.
`timescale 1ns / 100ps

module nmea_verdict_checker
  import nlfc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [7:0]   s_tdata,   // rx_byte
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [111:0] m_tdata,   // line_length, computed_sum, sentence_total,
                                  // error_total, byte_total, link_alive
  input  logic         m_tuser,   // sentence_ok
  output int           fail_count,
  output int           verdicts_pending
);

  // Predicted framer state.
  logic [FILL_W-1:0] fill;
  logic              overrun;
  logic              has_dollar;
  logic [7:0]        xor_acc;
  logic [FILL_W-1:0] star_at;
  logic              star_found;
  logic [7:0]        xor_star;
  logic [7:0]        hex_hi;
  logic [7:0]        hex_lo;
  logic [CNT_W-1:0]  good_lines;
  logic [CNT_W-1:0]  bad_lines;
  logic [CNT_W-1:0]  rx_count;
  logic              link_up;

  result_t verdict_q[$];

  initial begin
    fail_count = 0;
    verdicts_pending = 0;
  end

  // Returns the digit value, or -1 for a byte that is no hex digit.
  function automatic int hex_digit(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    return -1;
  endfunction

  task automatic report(input string msg);
    $display("%0t: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report($sformatf("field %s is %0h, expected %0h", name, got, want));
    end
  endtask

  task automatic clear_prediction();
    fill = '0;
    overrun = 1'b0;
    has_dollar = 1'b0;
    xor_acc = '0;
    star_at = '0;
    star_found = 1'b0;
    xor_star = '0;
    hex_hi = '0;
    hex_lo = '0;
    good_lines = '0;
    bad_lines = '0;
    rx_count = '0;
    link_up = 1'b0;
  endtask

  task automatic absorb_byte(input logic [7:0] c);
    result_t v;
    int      hi;
    int      lo;
    logic    ok;
    rx_count = rx_count + 1;
    if (c == CH_DOLLAR) begin
      fill = '0;
      overrun = 1'b0;
    end
    if (c == CH_CR || c == CH_LF) begin
      if (fill != 0 && !overrun) begin
        hi = hex_digit(hex_hi);
        lo = hex_digit(hex_lo);
        ok = int'(fill) >= MIN_LEN && has_dollar && star_found &&
             int'(star_at) + STAR_TAIL > int'(fill) &&
             int'(star_at) + HEX_DIGITS < int'(fill) &&
             hi >= 0 && lo >= 0 && (hi * 16 + lo) == int'(xor_star);
        if (ok) begin
          good_lines = good_lines + 1;
          link_up = 1'b1;
        end else begin
          bad_lines = bad_lines + 1;
        end
        v.ok = ok;
        v.len = fill;
        v.sum = star_found ? xor_star : 8'h00;
        v.sent = good_lines;
        v.err = bad_lines;
        v.bytes = rx_count;
        v.alive = link_up;
        verdict_q.push_back(v);
      end
      fill = '0;
      overrun = 1'b0;
    end else if (int'(fill) >= LINE_MAX) begin
      overrun = 1'b1;
    end else begin
      if (fill == 0) begin
        has_dollar = (c == CH_DOLLAR);
        xor_acc = '0;
        star_at = '0;
        star_found = 1'b0;
        xor_star = '0;
        hex_hi = '0;
        hex_lo = '0;
      end else begin
        if (star_found && int'(fill) == int'(star_at) + 1) hex_hi = c;
        if (star_found && int'(fill) == int'(star_at) + 2) hex_lo = c;
        if (c == CH_STAR) begin
          star_at = fill;
          star_found = 1'b1;
          xor_star = xor_acc;
        end
        xor_acc = xor_acc ^ c;
      end
      fill = fill + 1'b1;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      clear_prediction();
      verdict_q.delete();
    end else begin
      // A result word never belongs to the byte taken at the same edge.
      if (m_tvalid && m_tready) begin
        if (verdict_q.size() == 0) begin
          report("result word with no verdict pending");
        end else begin
          want = verdict_q.pop_front();
          check_field("sentence_ok", 32'(m_tuser), 32'(want.ok));
          check_field("line_length", 32'(m_tdata[6:0]), 32'(want.len));
          check_field("computed_sum", 32'(m_tdata[14:7]), 32'(want.sum));
          check_field("sentence_total", m_tdata[46:15], want.sent);
          check_field("error_total", m_tdata[78:47], want.err);
          check_field("byte_total", m_tdata[110:79], want.bytes);
          check_field("link_alive", 32'(m_tdata[111]), 32'(want.alive));
        end
      end
      if (s_tvalid && s_tready) absorb_byte(s_tdata);
    end
    verdicts_pending = verdict_q.size();
  end

endmodule

### tb/testbench.sv
// Top of the NMEA line framer testbench: clock, reset, byte stimulus and verdict.
`timescale 1ns / 100ps

module testbench;
  import nlfc_pkg::*;

  localparam int          BYTE_TARGET = 1650;
  localparam int          HOLD_LEN = 300;
  localparam logic [7:0]  CH_COMMA = 8'h2C;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic [7:0]   s_tdata = 8'h00;
  logic         m_tready = 1'b0;
  wire          s_tready;
  wire          m_tvalid;
  wire  [111:0] m_tdata;
  wire          m_tuser;

  int fail_count;
  int verdicts_pending;

  int idle_pct = 0;
  int stall_pct = 0;
  int sent_bytes = 0;
  int held = 0;
  bit hold_wanted = 1'b0;

  int idle_tab[4] = '{0, 81, 0, 28};
  int stall_tab[4] = '{0, 0, 81, 28};

  logic [7:0] line_q[$];

  nmea_line_framer_checksum_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  nmea_verdict_checker verdict_chk (
    .clk              (clk),
    .rst              (rst),
    .s_tvalid         (s_tvalid),
    .s_tready         (s_tready),
    .s_tdata          (s_tdata),
    .m_tvalid         (m_tvalid),
    .m_tready         (m_tready),
    .m_tdata          (m_tdata),
    .m_tuser          (m_tuser),
    .fail_count       (fail_count),
    .verdicts_pending (verdicts_pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("testbench failed");
    $finish;
  end

  // Receiver side: random stalls, plus one long hold-off once it is requested.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_wanted && held < HOLD_LEN) begin
        m_tready <= 1'b0;
        held++;
      end else begin
        m_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent_bytes++;
  endtask

  task automatic send_text(input string s, input logic [7:0] term);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    send_byte(term);
  endtask

  // Printable payload byte, now and then one above the ASCII range.
  function automatic logic [7:0] body_char();
    logic [7:0] c;
    if ($urandom_range(19) == 0) return 8'($urandom_range(128, 255));
    c = 8'($urandom_range(32, 126));
    while (c == CH_DOLLAR || c == CH_STAR) c = 8'($urandom_range(32, 126));
    return c;
  endfunction

  // Any byte that neither ends nor restarts the line.
  function automatic logic [7:0] stray_byte();
    logic [7:0] c;
    c = 8'($urandom_range(255));
    while (c == CH_CR || c == CH_LF || c == CH_DOLLAR) c = 8'($urandom_range(255));
    return c;
  endfunction

  function automatic logic [7:0] hex_ascii(input logic [3:0] n, input bit lower);
    if (n < 10) return 8'("0") + 8'(n);
    return (lower ? 8'("a") : 8'("A")) + 8'(n) - 8'd10;
  endfunction

  task automatic build_sentence(input int blen);
    logic [7:0] sum;
    logic [7:0] c;
    sum = 8'h00;
    line_q.push_back(CH_DOLLAR);
    repeat (blen) begin
      c = body_char();
      sum = sum ^ c;
      line_q.push_back(c);
    end
    line_q.push_back(CH_STAR);
    line_q.push_back(hex_ascii(sum[7:4], 1'($urandom_range(1))));
    line_q.push_back(hex_ascii(sum[3:0], 1'($urandom_range(1))));
  endtask

  task automatic push_terminator();
    case ($urandom_range(3))
      0: line_q.push_back(CH_CR);
      1: line_q.push_back(CH_LF);
      2: begin
        line_q.push_back(CH_CR);
        line_q.push_back(CH_LF);
      end
      default: begin
        line_q.push_back(CH_LF);
        line_q.push_back(CH_LF);
      end
    endcase
  endtask

  task automatic send_random_line();
    int kind;
    int blen;
    int star_idx;
    line_q.delete();
    kind = $urandom_range(99);
    if (kind < 85) begin
      blen = ($urandom_range(9) == 0) ? $urandom_range(25, 78) : $urandom_range(0, 24);
      star_idx = 1 + blen;
      build_sentence(blen);
      // Roughly 25 of every 85 sentences get broken in one way or another.
      if (kind >= 60) begin
        case ($urandom_range(6))
          0: line_q[line_q.size() - 1] = line_q[line_q.size() - 1] ^ 8'h01;
          1: line_q[line_q.size() - 1 - $urandom_range(1)] = stray_byte();
          2: line_q[star_idx] = CH_COMMA;
          3: repeat ($urandom_range(1, 4)) line_q.push_back(body_char());
          4: repeat ($urandom_range(1, 2)) void'(line_q.pop_back());
          5: line_q[0] = body_char();
          default: if (blen > 0) line_q[$urandom_range(1, blen)] = CH_STAR;
        endcase
      end
    end else if (kind < 90) begin
      // Overlong line, sometimes rescued by a new '$' before any terminator.
      line_q.push_back(CH_DOLLAR);
      repeat ($urandom_range(82, 100)) line_q.push_back(body_char());
      if ($urandom_range(1)) build_sentence($urandom_range(0, 12));
    end else begin
      repeat ($urandom_range(1, 8)) line_q.push_back(8'($urandom_range(255)));
    end
    if (kind >= 85 || $urandom_range(19) != 0) push_terminator();
    foreach (line_q[i]) send_byte(line_q[i]);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_text("$J*4a", CH_CR);
    send_byte(CH_LF);
    send_text("$o*6F", CH_LF);
    send_text("$*00", CH_CR);
    send_text("$J*4B", CH_CR);
    send_text("$J*G4", CH_CR);
    send_text("$J*4g", CH_LF);
    send_text("$GPGSA", CH_CR);
    send_text("$*", CH_CR);
    send_text("$", CH_LF);
    send_text("$A*41XYZW", CH_CR);
    send_text("$AB*0", CH_CR);
    send_text("GP*50", CH_CR);
    send_byte(CH_DOLLAR);
    send_byte(8'hC5);
    send_text("*C5", CH_CR);
    // Overrun dropped at the terminator, then overrun cleared by a new '$'.
    repeat (90) send_byte(body_char());
    send_byte(CH_CR);
    repeat (90) send_byte(body_char());
    send_text("$J*4a", CH_CR);

    hold_wanted = 1'b1;
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = idle_tab[ph];
      stall_pct = stall_tab[ph];
      while (sent_bytes < BYTE_TARGET * (ph + 1) / 4) send_random_line();
      s_tvalid <= 1'b0;
      // The edge waited here lets the checker count the verdict of the last byte taken.
      @(posedge clk);
      wait (verdicts_pending == 0);
      repeat (4) @(posedge clk);
    end

    repeat (20) @(posedge clk);
    if (fail_count == 0 && verdicts_pending == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
